// ----- rtl/ztt_pkg.sv -----
// Shared types and codes for the Zobrist-keyed transposition table.
// No dependencies; the top level refers to everything here by scoped name.
package ztt_pkg;

	typedef enum logic [2:0] {
		ACT_LOAD_PIECE = 3'd0,
		ACT_LOAD_SIDE  = 3'd1,
		ACT_CLEAR_KEY  = 3'd2,
		ACT_TOGGLE     = 3'd3,
		ACT_PROBE      = 3'd4,
		ACT_RECORD     = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		BOUND_EXACT = 2'd0,
		BOUND_UPPER = 2'd1,
		BOUND_LOWER = 2'd2
	} bound_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EXEC  = 4'b0010,
		ST_MOD   = 4'b0100,
		ST_CLEAR = 4'b1000
	} state_t;

	typedef struct packed {
		logic               valid;
		logic [7:0]         depth;
		logic signed [15:0] score;
		logic [1:0]         kind;
	} entry_info_t;

	localparam int KEY_W      = 64;
	localparam int MOD_STEP   = 4;
	localparam int MOD_CYCLES = KEY_W / MOD_STEP;

endpackage

// ----- rtl/zobrist_transposition_table_top.sv -----
// Top level of the Zobrist-keyed transposition table: piece key store, running
// position key and direct-mapped search table. Depends on ztt_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one action per transfer: load a
//   piece key, load the side key, clear the position key, toggle a piece, probe
//   the table or record an entry. Output channel (out_valid / out_stall) returns
//   exactly one result per action: hit, score_out and the position key after
//   the action.
//   An accepted transfer is captured with its synchronous key store and table
//   reads, then its result is registered in the output register after the
//   compare / write-back step; no new action is accepted until that is done.
//   When TABLE_ENTRIES is not a power of two, an in-range toggle is
//   followed by a remainder unit that folds the new key into a table index
//   4 bits per cycle, and the next transfer waits until it has finished.
//   Reset: control state, side key and position key clear at once; then a
//   clearing pass zeroes the info of every table entry, during which
//   in_stall stays high.
//   Receiver stall: the result waits in the output register; the next action
//   is still accepted and read, and its result waits until the register frees.
module zobrist_transposition_table_top #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int PIECE_KINDS   = 32,
	parameter int BOARD_COLS    = 16,
	parameter int BOARD_ROWS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic               colour,
	input  logic [4:0]         piece_kind,
	input  logic [3:0]         pos_x,
	input  logic [3:0]         pos_y,
	input  logic [63:0]        key_word,
	input  logic [7:0]         search_depth,
	input  logic signed [15:0] alpha_bound,
	input  logic signed [15:0] beta_bound,
	input  logic signed [15:0] score_in,
	input  logic [1:0]         bound_kind,

	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic signed [15:0] score_out,
	output logic [63:0]        position_key
);

	localparam int PIECE_SLOTS = 2 * PIECE_KINDS * BOARD_COLS * BOARD_ROWS;
	localparam int PSW         = $clog2(PIECE_SLOTS);
	localparam int IW          = $clog2(TABLE_ENTRIES);
	localparam bit IDX_POW2    = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
	localparam int MCW         = $clog2(ztt_pkg::MOD_CYCLES);

	// Storage
	logic [63:0]          piece_mem [PIECE_SLOTS];
	logic [63:0]          tag_mem   [TABLE_ENTRIES];
	ztt_pkg::entry_info_t info_mem  [TABLE_ENTRIES];

	// Control and architectural state
	ztt_pkg::state_t state_q;
	logic [63:0]     running_q;
	logic [63:0]     side_q;
	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   clr_cnt_q;
	logic [IW-1:0]   rem_q;
	logic [63:0]     mod_key_q;
	logic [MCW-1:0]  mod_cnt_q;

	// Captured item
	logic [2:0]         act_s1;
	logic [PSW-1:0]     slot_s1;
	logic               in_range_s1;
	logic [63:0]        key_word_s1;
	logic [7:0]         depth_s1;
	logic signed [15:0] alpha_s1;
	logic signed [15:0] beta_s1;
	logic signed [15:0] score_s1;
	logic [1:0]         kind_s1;

	// Memory read data
	logic [63:0]          pk_rd_s1;
	logic [63:0]          tag_rd_s1;
	ztt_pkg::entry_info_t info_rd_s1;

	// Output register
	logic               out_valid_q;
	logic               hit_q;
	logic signed [15:0] score_q;
	logic [63:0]        key_out_q;

	logic               accept;
	logic               exec_go;
	logic [PSW-1:0]     slot;
	logic               in_range;
	logic [63:0]        new_key;
	logic               probe_hit;
	logic signed [15:0] probe_score;
	logic               start_mod;
	logic [IW-1:0]      rem_next;
	logic               pk_we;
	logic               info_we;
	logic               tag_we;
	logic [IW-1:0]      tab_waddr;
	ztt_pkg::entry_info_t info_wdata;

	assign in_stall = (state_q != ztt_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign exec_go  = (state_q == ztt_pkg::ST_EXEC) && (!out_valid_q || !out_stall);

	// Piece key address and range check
	always_comb begin
		in_range = (32'(piece_kind) < PIECE_KINDS) && (32'(pos_x) < BOARD_COLS) &&
			(32'(pos_y) < BOARD_ROWS);
		slot = PSW'(((32'(colour) * PIECE_KINDS + 32'(piece_kind)) * BOARD_COLS +
			32'(pos_x)) * BOARD_ROWS + 32'(pos_y));
	end

	// Execute: key update and probe decision
	always_comb begin
		new_key     = running_q;
		start_mod   = 1'b0;
		probe_hit   = 1'b0;
		probe_score = '0;
		case (act_s1)
			ztt_pkg::ACT_CLEAR_KEY: begin
				new_key = '0;
			end
			ztt_pkg::ACT_TOGGLE: begin
				if (in_range_s1) begin
					new_key   = running_q ^ pk_rd_s1 ^ side_q;
					start_mod = 1'b1;
				end
			end
			ztt_pkg::ACT_PROBE: begin
				if (info_rd_s1.valid && tag_rd_s1 == running_q &&
				    info_rd_s1.depth >= depth_s1) begin
					if (info_rd_s1.kind == ztt_pkg::BOUND_EXACT) begin
						probe_hit   = 1'b1;
						probe_score = info_rd_s1.score;
					end else if (info_rd_s1.kind == ztt_pkg::BOUND_UPPER &&
					             info_rd_s1.score <= alpha_s1) begin
						probe_hit   = 1'b1;
						probe_score = alpha_s1;
					end else if (info_rd_s1.kind == ztt_pkg::BOUND_LOWER &&
					             info_rd_s1.score >= beta_s1) begin
						probe_hit   = 1'b1;
						probe_score = beta_s1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Remainder unit: fold MOD_STEP key bits per cycle, MSB first
	always_comb begin
		logic [IW:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < ztt_pkg::MOD_STEP; i++) begin
			r = {r[IW-1:0], mod_key_q[63 - i]};
			if (r >= (IW+1)'(TABLE_ENTRIES))
				r = r - (IW+1)'(TABLE_ENTRIES);
		end
		rem_next = r[IW-1:0];
	end

	// Memory write controls
	always_comb begin
		pk_we      = exec_go && act_s1 == ztt_pkg::ACT_LOAD_PIECE && in_range_s1;
		tag_we     = exec_go && act_s1 == ztt_pkg::ACT_RECORD;
		info_we    = tag_we || (state_q == ztt_pkg::ST_CLEAR);
		tab_waddr  = (state_q == ztt_pkg::ST_CLEAR) ? clr_cnt_q : idx_q;
		info_wdata = '0;
		if (state_q != ztt_pkg::ST_CLEAR) begin
			info_wdata.valid = 1'b1;
			info_wdata.depth = depth_s1;
			info_wdata.score = score_s1;
			info_wdata.kind  = kind_s1;
		end
	end

	// Piece key store: write on load, read on every accepted transfer
	always_ff @(posedge clk) begin
		if (pk_we)
			piece_mem[slot_s1] <= key_word_s1;
		if (accept)
			pk_rd_s1 <= piece_mem[slot];
	end

	// Table tags
	always_ff @(posedge clk) begin
		if (tag_we)
			tag_mem[idx_q] <= running_q;
		if (accept)
			tag_rd_s1 <= tag_mem[idx_q];
	end

	// Table info, also swept by the clearing pass
	always_ff @(posedge clk) begin
		if (info_we)
			info_mem[tab_waddr] <= info_wdata;
		if (accept)
			info_rd_s1 <= info_mem[idx_q];
	end

	// Capture the item on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1      <= action;
			slot_s1     <= slot;
			in_range_s1 <= in_range;
			key_word_s1 <= key_word;
			depth_s1    <= search_depth;
			alpha_s1    <= alpha_bound;
			beta_s1     <= beta_bound;
			score_s1    <= score_in;
			kind_s1     <= bound_kind;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (exec_go) begin
			hit_q     <= probe_hit;
			score_q   <= probe_score;
			key_out_q <= new_key;
		end
	end

	// Remainder datapath
	always_ff @(posedge clk) begin
		if (exec_go && start_mod) begin
			mod_key_q <= new_key;
			rem_q     <= '0;
		end else if (state_q == ztt_pkg::ST_MOD) begin
			mod_key_q <= mod_key_q << ztt_pkg::MOD_STEP;
			rem_q     <= rem_next;
		end
	end

	// Sequencer, key registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ztt_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			mod_cnt_q   <= '0;
			running_q   <= '0;
			side_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new result, or drop the one just taken
			if (exec_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ztt_pkg::ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == IW'(TABLE_ENTRIES - 1))
						state_q <= ztt_pkg::ST_IDLE;
				end
				ztt_pkg::ST_IDLE: begin
					if (accept)
						state_q <= ztt_pkg::ST_EXEC;
				end
				ztt_pkg::ST_EXEC: begin
					if (exec_go) begin
						running_q   <= new_key;
						if (act_s1 == ztt_pkg::ACT_LOAD_SIDE)
							side_q <= key_word_s1;
						if (act_s1 == ztt_pkg::ACT_CLEAR_KEY)
							idx_q <= '0;
						if (start_mod && IDX_POW2) begin
							idx_q   <= new_key[IW-1:0];
							state_q <= ztt_pkg::ST_IDLE;
						end else if (start_mod) begin
							mod_cnt_q <= '0;
							state_q   <= ztt_pkg::ST_MOD;
						end else begin
							state_q <= ztt_pkg::ST_IDLE;
						end
					end
				end
				ztt_pkg::ST_MOD: begin
					mod_cnt_q <= mod_cnt_q + 1'b1;
					if (mod_cnt_q == MCW'(ztt_pkg::MOD_CYCLES - 1)) begin
						idx_q   <= rem_next;
						state_q <= ztt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ztt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign score_out    = score_q;
	assign position_key = key_out_q;

endmodule
